// ----- sv/tsrb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsrb_pkg
// Shared types and codes for the two-section ring buffer allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrb_pkg;

    localparam int unsigned DEFAULT_BUFFER_BYTES = 1024;
    localparam int unsigned FIELD_W              = 10;
    localparam int unsigned STATUS_W             = 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] write_len;
        logic [FIELD_W-1:0] read_len;
        logic [FIELD_W-1:0] write_start_in;
        logic [FIELD_W-1:0] read_start_in;
    } tsrb_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] op_status;
        logic [FIELD_W-1:0]  write_start_out;
        logic [FIELD_W-1:0]  read_start_out;
        logic [FIELD_W-1:0]  space_back;
        logic [FIELD_W-1:0]  space_front;
    } tsrb_rsp_t;

endpackage

`default_nettype wire

// ----- sv/tsrb_alloc.sv -----
// ----------------------------------------------------------------------------
// tsrb_alloc
// Single-pass allocate/free datapath: next pointers and result for one
// transaction, given the current start and end pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrb_alloc
    import tsrb_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = DEFAULT_BUFFER_BYTES,
    localparam int unsigned PTR_W = $clog2(BUFFER_BYTES)
)
(
    input  tsrb_req_t        req,
    input  logic [PTR_W-1:0] start_ptr,
    input  logic [PTR_W-1:0] end_ptr,
    output logic [PTR_W-1:0] start_ptr_next,
    output logic [PTR_W-1:0] end_ptr_next,
    output tsrb_rsp_t        rsp
);

    localparam int unsigned CW = ((PTR_W > FIELD_W) ? PTR_W : FIELD_W) + 2;
    localparam logic [CW-1:0] BUF_C = CW'(BUFFER_BYTES);

    // Free pieces {back, front}, each less one guard byte when nonzero.
    function automatic logic [2*CW-1:0] space(input logic [CW-1:0] s,
                                              input logic [CW-1:0] e);
        logic [CW-1:0] b;
        logic [CW-1:0] f;
        if (s <= e)
        begin
            b = BUF_C - e;
            f = s;
        end
        else
        begin
            b = s - e;
            f = '0;
        end
        if (b != '0)
            b = b - CW'(1);
        if (f != '0)
            f = f - CW'(1);
        return {b, f};
    endfunction

    logic [CW-1:0] s_cur, e_cur, back0, front0;
    logic [CW-1:0] wsz, rsz, wst, rst, sa, sb;
    logic          w_first;
    logic          a_back, a_front, b_back, b_front, alloc_ok;
    logic [CW-1:0] pos_a, pos_b, boff1, foff1, back1, front1, boff2, foff2;
    logic [CW-1:0] alloc_end, wpos, rpos;
    logic [CW-1:0] ns;
    logic          free_ok;
    logic [CW-1:0] s_new, e_new, back_n, front_n;
    logic [STATUS_W-1:0] status;

    always_comb
    begin
        s_cur = CW'(start_ptr);
        e_cur = CW'(end_ptr);
        {back0, front0} = space(s_cur, e_cur);

        wsz = CW'(req.write_len);
        rsz = CW'(req.read_len);
        wst = CW'(req.write_start_in);
        rst = CW'(req.read_start_in);

        // Larger section goes first, write on a tie.
        w_first = (wsz >= rsz);
        sa = w_first ? wsz : rsz;
        sb = w_first ? rsz : wsz;

        a_back  = (back0 >= sa);
        a_front = !a_back && (front0 >= sa);
        pos_a   = a_back ? e_cur : '0;
        boff1   = a_back ? e_cur + sa : e_cur;
        foff1   = a_front ? sa : '0;
        back1   = a_back ? back0 - sa : back0;
        front1  = a_front ? front0 - sa : front0;

        b_back  = (back1 >= sb);
        b_front = !b_back && (front1 >= sb);
        pos_b   = b_back ? boff1 : foff1;
        boff2   = b_back ? boff1 + sb : boff1;
        foff2   = b_front ? foff1 + sb : foff1;

        alloc_ok  = (a_back || a_front) && (b_back || b_front);
        alloc_end = (foff2 == '0) ? boff2 : foff2;
        wpos = w_first ? pos_a : pos_b;
        rpos = w_first ? pos_b : pos_a;

        // Free: skip both sections of the oldest transaction.
        ns = '0;
        free_ok = 1'b1;
        priority if (s_cur == wst)
        begin
            ns = s_cur + wsz;
            if (ns == rst)
                ns = ns + rsz;
            else if (rst == '0)
                ns = rsz;
            else
                free_ok = 1'b0;
        end
        else if (s_cur == rst)
        begin
            ns = s_cur + rsz;
            if (ns == wst)
                ns = ns + wsz;
            else if (wst == '0)
                ns = wsz;
            else
                free_ok = 1'b0;
        end
        else if (wst == '0 || rst == '0)
        begin
            ns = wsz + rsz;
        end
        else
        begin
            free_ok = 1'b0;
        end
        if (ns >= BUF_C)
            free_ok = 1'b0;

        s_new  = s_cur;
        e_new  = e_cur;
        status = ST_OK;
        rsp.write_start_out = '0;
        rsp.read_start_out  = '0;
        unique case (req.req_type)
            REQ_ALLOC:
            begin
                if (alloc_ok)
                begin
                    e_new = alloc_end;
                    rsp.write_start_out = wpos[FIELD_W-1:0];
                    rsp.read_start_out  = rpos[FIELD_W-1:0];
                end
                else
                begin
                    status = ST_NO_SPACE;
                end
            end
            REQ_FREE:
            begin
                if (free_ok)
                begin
                    s_new = ns;
                    // Rewind both pointers once the buffer drains.
                    if (ns == e_cur)
                    begin
                        s_new = '0;
                        e_new = '0;
                    end
                end
                else
                begin
                    status = ST_MISMATCH;
                end
            end
            default:
            begin
                status = ST_MISMATCH;
            end
        endcase

        {back_n, front_n} = space(s_new, e_new);
        rsp.op_status   = status;
        rsp.space_back  = back_n[FIELD_W-1:0];
        rsp.space_front = front_n[FIELD_W-1:0];
        start_ptr_next  = s_new[PTR_W-1:0];
        end_ptr_next    = e_new[PTR_W-1:0];
    end

endmodule

`default_nettype wire

// ----- sv/two_section_ring_buffer_allocator.sv -----
// ----------------------------------------------------------------------------
// two_section_ring_buffer_allocator
// Circular buffer allocator handing out write/read section pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start for one cycle per transaction; a
//   transaction is taken at a rising edge with start high and busy low.
//   busy stays low, so a transaction may be issued on every cycle.
//   req_type selects allocate (place two sections, advance the end pointer)
//   or free (advance the start pointer past the oldest pair).
//   Each transaction yields one result on the result port, marked by done
//   for exactly one cycle: the request is registered, then the
//   single-pass allocate/free logic feeds the result register and the
//   pointer registers.
//   Throughput is one transaction per cycle; a transaction sees the
//   pointers left by the one before it.
//   Every result carries the free back and front space after the operation.
//   Reset clears both pointers and drops any transaction in flight.
//   The receiver cannot stall: a result is valid only in its done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_section_ring_buffer_allocator
    import tsrb_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = DEFAULT_BUFFER_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tsrb_req_t request,
    output logic      done,
    output tsrb_rsp_t result
);

    localparam int unsigned PTR_W = $clog2(BUFFER_BYTES);

    logic             valid_reg;
    tsrb_req_t        req_reg;
    logic             done_reg;
    tsrb_rsp_t        result_reg;
    logic [PTR_W-1:0] start_ptr_reg, end_ptr_reg;
    logic [PTR_W-1:0] start_ptr_next, end_ptr_next;
    tsrb_rsp_t        rsp_next;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    tsrb_alloc #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_alloc (
        .req            (req_reg),
        .start_ptr      (start_ptr_reg),
        .end_ptr        (end_ptr_reg),
        .start_ptr_next (start_ptr_next),
        .end_ptr_next   (end_ptr_next),
        .rsp            (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            done_reg      <= 1'b0;
            start_ptr_reg <= '0;
            end_ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
            if (valid_reg)
            begin
                start_ptr_reg <= start_ptr_next;
                end_ptr_reg   <= end_ptr_next;
            end
        end
    end

    // Payload registers: hold unless a transaction moves through.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= request;
        if (valid_reg)
            result_reg <= rsp_next;
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted transaction produced no result");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(start_ptr_reg) < BUFFER_BYTES) && (32'(end_ptr_reg) < BUFFER_BYTES))
        else $error("pointer beyond buffer");

    a_empty_rewound: assert property (@(posedge clk) disable iff (!rst_n)
        (start_ptr_reg == end_ptr_reg) |-> (start_ptr_reg == '0))
        else $error("empty buffer not rewound to zero");

    a_fail_holds_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.op_status != ST_OK) |->
            ($stable(start_ptr_reg) && $stable(end_ptr_reg)))
        else $error("failed transaction moved a pointer");

    a_fail_zero_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.op_status == ST_NO_SPACE) |->
            (result.write_start_out == '0 && result.read_start_out == '0))
        else $error("no-space result carries offsets");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-section ring buffer allocator. A built-in
// model of the pointer logic predicts every result; directed sequences cover
// empty/full buffers, section ordering, wrapped gaps and bad frees, then
// random allocate/free traffic with random idle gaps follows.
// ----------------------------------------------------------------------------
module tb
    import tsrb_pkg::*;
();

    localparam int unsigned BUF_BYTES = DEFAULT_BUFFER_BYTES;

    typedef struct {
        int unsigned w_off;
        int unsigned w_len;
        int unsigned r_off;
        int unsigned r_len;
    } live_pair_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    tsrb_req_t request = '0;
    logic      done;
    tsrb_rsp_t result;

    // model pointers: oldest live byte and next free byte
    int unsigned used_lo = 0;
    int unsigned used_hi = 0;

    tsrb_rsp_t  due_rsp_q[$];
    live_pair_t live_pairs[$];
    tsrb_rsp_t  due_rsp;
    int         fail_count = 0;
    bit         no_idle = 1'b0;

    always #5 clk = ~clk;

    two_section_ring_buffer_allocator #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    // back and front free pieces, each less one guard byte
    function automatic void free_pieces(output int unsigned bk, output int unsigned fr);
        if (used_lo <= used_hi)
        begin
            bk = BUF_BYTES - used_hi;
            fr = used_lo;
        end
        else
        begin
            bk = used_lo - used_hi;
            fr = 0;
        end
        if (bk > 0) bk--;
        if (fr > 0) fr--;
    endfunction

    function automatic bit place_section(inout int unsigned fr_off, inout int unsigned bk_off,
                                         inout int unsigned bk, inout int unsigned fr,
                                         output int unsigned pos, input int unsigned len);
        pos = 0;
        if (bk >= len)
        begin
            pos = bk_off;
            bk_off += len;
            bk -= len;
            return 1'b1;
        end
        if (fr >= len)
        begin
            pos = fr_off;
            fr_off += len;
            fr -= len;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one transaction to the model pointers and return its result.
    function automatic tsrb_rsp_t apply_request(input tsrb_req_t r);
        tsrb_rsp_t   rsp;
        int unsigned bk, fr, fr_off, bk_off, w_pos, r_pos, nxt;
        int unsigned wsz, rsz, wst, rst;
        bit          fits;
        rsp = '0;
        rsp.op_status = ST_OK;
        wsz = 32'(r.write_len);
        rsz = 32'(r.read_len);
        wst = 32'(r.write_start_in);
        rst = 32'(r.read_start_in);
        if (r.req_type == REQ_ALLOC)
        begin
            fr_off = 0;
            bk_off = used_hi;
            w_pos = 0;
            r_pos = 0;
            free_pieces(bk, fr);
            // larger section goes first, write wins a tie
            if (wsz >= rsz)
            begin
                fits = place_section(fr_off, bk_off, bk, fr, w_pos, wsz);
                if (fits) fits = place_section(fr_off, bk_off, bk, fr, r_pos, rsz);
            end
            else
            begin
                fits = place_section(fr_off, bk_off, bk, fr, r_pos, rsz);
                if (fits) fits = place_section(fr_off, bk_off, bk, fr, w_pos, wsz);
            end
            if (fits)
            begin
                used_hi = (fr_off == 0) ? bk_off : fr_off;
                rsp.write_start_out = w_pos[FIELD_W-1:0];
                rsp.read_start_out = r_pos[FIELD_W-1:0];
            end
            else
            begin
                rsp.op_status = ST_NO_SPACE;
            end
        end
        else
        begin
            fits = 1'b1;
            nxt = 0;
            if (used_lo == wst)
            begin
                nxt = used_lo + wsz;
                if (nxt == rst) nxt += rsz;
                else if (rst == 0) nxt = rsz;
                else fits = 1'b0;
            end
            else if (used_lo == rst)
            begin
                nxt = used_lo + rsz;
                if (nxt == wst) nxt += wsz;
                else if (wst == 0) nxt = wsz;
                else fits = 1'b0;
            end
            else if (wst == 0 || rst == 0)
            begin
                nxt = wsz + rsz;
            end
            else
            begin
                fits = 1'b0;
            end
            if (fits && nxt >= BUF_BYTES) fits = 1'b0;
            if (fits)
            begin
                used_lo = nxt;
                if (used_lo == used_hi)
                begin
                    used_lo = 0;
                    used_hi = 0;
                end
            end
            else
            begin
                rsp.op_status = ST_MISMATCH;
            end
        end
        free_pieces(bk, fr);
        rsp.space_back = bk[FIELD_W-1:0];
        rsp.space_front = fr[FIELD_W-1:0];
        return rsp;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 0;
        if (roll < 78) return $urandom_range(1, 120);
        if (roll < 94) return $urandom_range(121, 500);
        return $urandom_range(501, 1023);
    endfunction

    // Send one transaction, predict its result and track live allocations.
    task automatic send_req(input tsrb_req_t r);
        int        gap;
        tsrb_rsp_t want;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        want = apply_request(r);
        due_rsp_q.push_back(want);
        if (r.req_type == REQ_ALLOC && want.op_status == ST_OK)
            live_pairs.push_back('{32'(want.write_start_out), 32'(r.write_len),
                                   32'(want.read_start_out), 32'(r.read_len)});
    endtask

    task automatic alloc_pair(input int unsigned wsz, input int unsigned rsz);
        tsrb_req_t r;
        r.req_type = REQ_ALLOC;
        r.write_len = wsz[FIELD_W-1:0];
        r.read_len = rsz[FIELD_W-1:0];
        r.write_start_in = FIELD_W'($urandom_range(0, 1023));
        r.read_start_in = FIELD_W'($urandom_range(0, 1023));
        send_req(r);
    endtask

    task automatic send_free(input int unsigned wst, input int unsigned wsz,
                             input int unsigned rst, input int unsigned rsz);
        tsrb_req_t r;
        r.req_type = REQ_FREE;
        r.write_len = wsz[FIELD_W-1:0];
        r.read_len = rsz[FIELD_W-1:0];
        r.write_start_in = wst[FIELD_W-1:0];
        r.read_start_in = rst[FIELD_W-1:0];
        send_req(r);
    endtask

    // Free the whole occupied region in one transaction; resyncs the
    // pair list after noise has moved the start pointer.
    task automatic drain_buffer();
        live_pairs.delete();
        if (used_lo <= used_hi)
            send_free(used_lo, used_hi - used_lo, used_hi, 0);
        else
            send_free(used_lo, 0, 0, used_hi);
    endtask

    task automatic free_oldest();
        live_pair_t p;
        if (live_pairs.size() == 0)
        begin
            drain_buffer();
        end
        else
        begin
            p = live_pairs.pop_front();
            send_free(p.w_off, p.w_len, p.r_off, p.r_len);
        end
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        while (due_rsp_q.size() != 0) @(posedge clk);
        repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    task automatic test_empty_and_full();
        alloc_pair(0, 0);
        free_oldest();
        alloc_pair(1023, 0);
        // nothing left on either side
        alloc_pair(1, 1);
        send_free(5, 1, 7, 1);
        free_oldest();
    endtask

    task automatic test_section_order();
        alloc_pair(100, 300);
        alloc_pair(200, 200);
        free_oldest();
        // write spills to the front, read stays at the back
        alloc_pair(300, 150);
        free_oldest();
        free_oldest();
    endtask

    task automatic test_wrapped_gap();
        alloc_pair(500, 0);
        alloc_pair(400, 0);
        free_oldest();
        // both sections land at the front
        alloc_pair(150, 150);
        free_oldest();
        free_oldest();
    endtask

    task automatic test_bad_frees();
        // new start pointer would run past the buffer
        send_free(0, 1023, 1023, 1);
        send_free(1023, 1023, 1023, 1023);
        alloc_pair(1023, 1023);
    endtask

    task automatic test_back_to_back_then_pause();
        no_idle = 1'b1;
        repeat (3) alloc_pair(pick_size(), pick_size());
        pause_until_drained();
        repeat (3) free_oldest();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        tsrb_req_t r;
        int        roll;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i % 400 == 399) pause_until_drained();
            roll = $urandom_range(0, 99);
            if (roll < 18)
            begin
                r.req_type = 1'($urandom_range(0, 1));
                r.write_len = FIELD_W'($urandom_range(0, 1023));
                r.read_len = FIELD_W'($urandom_range(0, 1023));
                r.write_start_in = FIELD_W'($urandom_range(0, 1023));
                r.read_start_in = FIELD_W'($urandom_range(0, 1023));
                // aim one offset at the start pointer to reach partial matches
                case ($urandom_range(0, 2))
                    1: r.write_start_in = used_lo[FIELD_W-1:0];
                    2: r.read_start_in = used_lo[FIELD_W-1:0];
                    default: ;
                endcase
                send_req(r);
            end
            else if (roll < 20)
            begin
                drain_buffer();
            end
            else if (live_pairs.size() == 0 || roll < (live_pairs.size() > 6 ? 45 : 62))
            begin
                alloc_pair(pick_size(), pick_size());
            end
            else
            begin
                free_oldest();
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (due_rsp_q.size() == 0)
            begin
                $error("result transaction with none expected");
                fail_count++;
            end
            else
            begin
                due_rsp = due_rsp_q.pop_front();
                if (result.op_status !== due_rsp.op_status)
                begin
                    $error("op_status expected %0d got %0d", due_rsp.op_status, result.op_status);
                    fail_count++;
                end
                if (result.write_start_out !== due_rsp.write_start_out)
                begin
                    $error("write_start_out expected %0d got %0d",
                           due_rsp.write_start_out, result.write_start_out);
                    fail_count++;
                end
                if (result.read_start_out !== due_rsp.read_start_out)
                begin
                    $error("read_start_out expected %0d got %0d",
                           due_rsp.read_start_out, result.read_start_out);
                    fail_count++;
                end
                if (result.space_back !== due_rsp.space_back)
                begin
                    $error("space_back expected %0d got %0d",
                           due_rsp.space_back, result.space_back);
                    fail_count++;
                end
                if (result.space_front !== due_rsp.space_front)
                begin
                    $error("space_front expected %0d got %0d",
                           due_rsp.space_front, result.space_front);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_full();
        test_section_order();
        test_wrapped_gap();
        test_bad_frees();
        test_back_to_back_then_pause();
        test_random_traffic(1300);
        start <= 1'b0;
        for (k = 0; k < 200 && due_rsp_q.size() != 0; k++) @(posedge clk);
        if (due_rsp_q.size() != 0)
        begin
            $error("%0d expected results never arrived", due_rsp_q.size());
            fail_count++;
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

endmodule
